### rtl/php_pkg.sv
`timescale 1ns / 1ps

package php_pkg;

  localparam int unsigned CODE_WORDS_DEF    = 65536;
  localparam int unsigned TOP_K_DEF         = 15;
  localparam int unsigned MAX_FUNCTIONS_DEF = 16384;
  localparam int unsigned COUNTER_BITS_DEF  = 32;

  localparam logic [31:0] BASE_RESET = 32'h0804_8000;
  localparam int unsigned SUM_BITS   = 48;
  localparam int unsigned ID_BITS    = 16;
  localparam int unsigned RANK_BITS  = 4;
  localparam logic [SUM_BITS-1:0] SUM_MAX = '1;

  typedef enum logic [1:0] {
    OP_RECORD = 2'd0,
    OP_ADD    = 2'd1,
    OP_REPORT = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef struct packed {
    logic                valid;
    logic [SUM_BITS-1:0] hits;
    logic [ID_BITS-1:0]  id;
  } entry_t;

  typedef struct packed {
    logic clr;
    logic ins;
    logic shift;
  } cell_ctrl_t;

endpackage

### rtl/php_in_if.sv
`timescale 1ns / 1ps

interface php_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] pc;
  logic [31:0] range_start;
  logic [31:0] range_length;
  logic [15:0] function_id;

  modport source (
    output valid, operation, pc, range_start, range_length, function_id,
    input  ready
  );
  modport sink (
    input  valid, operation, pc, range_start, range_length, function_id,
    output ready
  );
endinterface

### rtl/php_out_if.sv
`timescale 1ns / 1ps

interface php_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  rank;
  logic [15:0] function_id_out;
  logic [47:0] hit_total;
  logic        entry_valid;
  logic        last;

  modport source (
    output valid, rank, function_id_out, hit_total, entry_valid, last,
    input  ready
  );
  modport sink (
    input  valid, rank, function_id_out, hit_total, entry_valid, last,
    output ready
  );
endinterface

### rtl/php_hit_mem.sv
`timescale 1ns / 1ps

module php_hit_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 8,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/php_cell.sv
`timescale 1ns / 1ps

module php_cell
  import php_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  entry_t     new_i,
  input  entry_t     prev_i,
  input  logic       prev_keep_i,
  input  entry_t     next_i,
  output entry_t     ent_o,
  output logic       keep_o
);

  entry_t ent_q;

  // an entry with at least as many hits stays ahead of the newcomer
  assign keep_o = ent_q.valid && (ent_q.hits >= new_i.hits);
  assign ent_o  = ent_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q.valid <= 1'b0;
    end else if (ctrl_i.clr) begin
      ent_q.valid <= 1'b0;
    end else if (ctrl_i.ins) begin
      if (!keep_o) begin
        ent_q <= prev_keep_i ? new_i : prev_i;
      end
    end else if (ctrl_i.shift) begin
      ent_q <= next_i;
    end
  end

endmodule

### rtl/pc_hit_profiler_top_k.sv
`timescale 1ns / 1ps

// PC hit profiler with a top-K function list. Hit counters live in a single-port-read
// memory of CODE_WORDS words; after reset and after every clear item the block sweeps
// that memory to zero with item ready low. A record item inside the window reads its
// counter, then writes back the incremented counter; one outside it has no effect.
// An add item walks the window one counter per cycle through the memory read port, the
// window span being min(CODE_WORDS, 2^32 - base); an add past the function limit has no
// effect. The list is a row of TOP_K cells that all take an insert together. A report
// sends one beat per entry (at least one) and holds while the result side stalls; a
// finished beat waits in an output register while the next item is taken.
module pc_hit_profiler_top_k
  import php_pkg::*;
#(
  parameter int unsigned CODE_WORDS    = CODE_WORDS_DEF,
  parameter int unsigned TOP_K         = TOP_K_DEF,
  parameter int unsigned MAX_FUNCTIONS = MAX_FUNCTIONS_DEF,
  parameter int unsigned COUNTER_BITS  = COUNTER_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  php_in_if.sink      item_i,
  php_out_if.source   result_o
);

  localparam int unsigned AW = $clog2(CODE_WORDS);
  localparam int unsigned FW = $clog2(MAX_FUNCTIONS + 1);
  localparam int unsigned SW = ((COUNTER_BITS > SUM_BITS) ? COUNTER_BITS : SUM_BITS) + 1;

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_REC, S_SUM, S_DRAIN, S_INS, S_REP
  } state_e;

  state_e                 state_q;
  logic [31:0]            base_q;
  logic [AW-1:0]          off_q;
  logic [31:0]            addr_q;
  logic [31:0]            start_q;
  logic [31:0]            len_q;
  logic [ID_BITS-1:0]     id_q;
  logic [SUM_BITS-1:0]    sum_q;
  logic                   rd_pend_q;
  logic                   hit_q;
  logic [FW-1:0]          fa_q;
  logic [RANK_BITS-1:0]   rank_q;

  logic                   out_valid_q;
  logic [RANK_BITS-1:0]   out_rank_q;
  logic [ID_BITS-1:0]     out_id_q;
  logic [SUM_BITS-1:0]    out_hits_q;
  logic                   out_ev_q;
  logic                   out_last_q;

  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [COUNTER_BITS-1:0] mem_wdata;
  logic [AW-1:0]          mem_raddr;
  logic [COUNTER_BITS-1:0] mem_rdata;

  logic [31:0]            rec_off;
  logic                   rec_hit;
  logic                   accept;
  op_e                    op;
  logic                   sweep_done;
  logic [SW-1:0]          sum_ext;
  logic                   out_free;
  logic                   head_last;

  cell_ctrl_t             ctrl;
  entry_t                 new_ent;
  entry_t                 ent [TOP_K+1];
  logic [TOP_K-1:0]       keep;
  logic [TOP_K-1:0]       cell_vld;

  assign item_i.ready = (state_q == S_IDLE);
  assign accept       = item_i.valid && item_i.ready;
  assign op           = op_e'(item_i.operation);

  assign rec_off = item_i.pc - base_q;
  assign rec_hit = (item_i.pc >= base_q) && (rec_off < 32'(CODE_WORDS));

  // the window ends at CODE_WORDS or at the top of the address space
  assign sweep_done = (off_q == AW'(CODE_WORDS - 1)) || (addr_q == 32'hFFFF_FFFF);

  assign sum_ext  = SW'(sum_q) + SW'(mem_rdata);
  assign out_free = !out_valid_q || result_o.ready;
  assign head_last = !ent[0].valid || !ent[1].valid;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = off_q;
    mem_wdata = '0;
    mem_raddr = off_q;
    case (state_q)
      S_CLR: begin
        mem_we = 1'b1;
      end
      S_IDLE: begin
        mem_raddr = rec_off[AW-1:0];
      end
      S_REC: begin
        mem_we    = 1'b1;
        mem_wdata = (&mem_rdata) ? mem_rdata : mem_rdata + COUNTER_BITS'(1);
      end
      default: begin
      end
    endcase
  end

  php_hit_mem #(
    .DEPTH (CODE_WORDS),
    .WIDTH (COUNTER_BITS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    ctrl.clr   = accept && (op == OP_CLEAR);
    ctrl.ins   = (state_q == S_INS);
    ctrl.shift = (state_q == S_REP) && out_free && ent[0].valid;
    new_ent.valid = 1'b1;
    new_ent.hits  = sum_q;
    new_ent.id    = id_q;
  end

  assign ent[TOP_K] = '0;

  for (genvar i = 0; i < TOP_K; i++) begin : g_cell
    php_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .new_i       (new_ent),
      .prev_i      ((i == 0) ? new_ent : ent[(i == 0) ? 0 : i-1]),
      .prev_keep_i ((i == 0) ? 1'b1 : keep[(i == 0) ? 0 : i-1]),
      .next_i      (ent[i+1]),
      .ent_o       (ent[i]),
      .keep_o      (keep[i])
    );
    assign cell_vld[i] = ent[i].valid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= BASE_RESET;
      state_q     <= S_CLR;
      off_q       <= '0;
      rd_pend_q   <= 1'b0;
      fa_q        <= '0;
      rank_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i;
      end

      rd_pend_q <= (state_q == S_SUM);
      if (rd_pend_q && hit_q) begin
        sum_q <= (sum_ext > SW'(SUM_MAX)) ? SUM_MAX : sum_ext[SUM_BITS-1:0];
      end

      // while reporting, the output register is refilled below instead
      if (out_valid_q && result_o.ready && (state_q != S_REP)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_CLR: begin
          if (off_q == AW'(CODE_WORDS - 1)) begin
            off_q   <= '0;
            state_q <= S_IDLE;
          end else begin
            off_q <= off_q + AW'(1);
          end
        end
        S_IDLE: begin
          if (accept) begin
            case (op)
              OP_RECORD: begin
                if (rec_hit) begin
                  off_q   <= rec_off[AW-1:0];
                  state_q <= S_REC;
                end
              end
              OP_ADD: begin
                if (fa_q < FW'(MAX_FUNCTIONS)) begin
                  fa_q    <= fa_q + FW'(1);
                  off_q   <= '0;
                  addr_q  <= base_q;
                  start_q <= item_i.range_start;
                  len_q   <= item_i.range_length;
                  id_q    <= item_i.function_id;
                  sum_q   <= '0;
                  state_q <= S_SUM;
                end
              end
              OP_REPORT: begin
                rank_q  <= '0;
                state_q <= S_REP;
              end
              OP_CLEAR: begin
                fa_q    <= '0;
                off_q   <= '0;
                state_q <= S_CLR;
              end
              default: begin
              end
            endcase
          end
        end
        S_REC: begin
          state_q <= S_IDLE;
        end
        S_SUM: begin
          // membership of this address travels with its read
          hit_q  <= (addr_q - start_q) < len_q;
          off_q  <= off_q + AW'(1);
          addr_q <= addr_q + 32'd1;
          if (sweep_done) begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state_q <= S_INS;
        end
        S_INS: begin
          state_q <= S_IDLE;
        end
        S_REP: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_rank_q  <= rank_q;
            out_ev_q    <= ent[0].valid;
            out_id_q    <= ent[0].valid ? ent[0].id : '0;
            out_hits_q  <= ent[0].valid ? ent[0].hits : '0;
            out_last_q  <= head_last;
            rank_q      <= rank_q + RANK_BITS'(1);
            if (head_last) begin
              fa_q    <= '0;
              state_q <= S_IDLE;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign result_o.valid           = out_valid_q;
  assign result_o.rank            = out_rank_q;
  assign result_o.function_id_out = out_id_q;
  assign result_o.hit_total       = out_hits_q;
  assign result_o.entry_valid     = out_ev_q;
  assign result_o.last            = out_last_q;

`ifndef SYNTH
  a_empty_beat_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && !result_o.entry_valid) |-> result_o.last)
    else $error("empty report beat without last");

  a_list_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cell_vld & (cell_vld + TOP_K'(1))) == '0)
    else $error("top list has a hole");

  a_fn_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fa_q <= FW'(MAX_FUNCTIONS))
    else $error("function count past limit");

  a_ins_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INS) |-> ($past(state_q) == S_DRAIN))
    else $error("insert without finished sweep");
`endif

endmodule

### tb/sv/tb_pc_hit_profiler_top_k.sv
`timescale 1ns / 1ps

module tb_pc_hit_profiler_top_k;
  import php_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam longint unsigned COUNT_MAX = {64{1'b1}} >> (64 - COUNTER_BITS_DEF);

  typedef struct {
    op_e         op;
    logic [31:0] pc;
    logic [31:0] range_start;
    logic [31:0] range_length;
    logic [15:0] func_id;
  } item_t;

  typedef struct {
    logic [3:0]  rank;
    logic [15:0] func_id;
    logic [47:0] hits;
    logic        entry_valid;
    logic        last;
  } beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  php_in_if  item_if ();
  php_out_if res_if ();

  pc_hit_profiler_top_k uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .item_i      (item_if),
    .result_o    (res_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow of the profiler state
  logic [31:0]     base_addr;
  longint unsigned hit_count [int unsigned];
  logic [47:0]     rank_hits [TOP_K_DEF];
  logic [15:0]     rank_ids  [TOP_K_DEF];
  bit              rank_used [TOP_K_DEF];
  int unsigned     funcs_taken;

  beat_t expected_beats [$];

  bit          src_calm;
  bit          sink_calm;
  int          sink_hold;
  int unsigned cycle_count;
  int unsigned fail_count;
  int unsigned items_sent;
  int unsigned beats_checked;
  int unsigned cfg_writes;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic longint unsigned window_span();
    longint unsigned room;
    room = 64'h1_0000_0000 - {32'h0, base_addr};
    return (room < CODE_WORDS_DEF) ? room : CODE_WORDS_DEF;
  endfunction

  function automatic logic [47:0] range_hits(input logic [31:0] start, input logic [31:0] len);
    longint unsigned total;
    longint unsigned span;
    logic [31:0]     addr;
    logic [31:0]     delta;
    total = 0;
    span  = window_span();
    foreach (hit_count[off]) begin
      addr  = base_addr + off;
      delta = addr - start;
      if (off < span && delta < len) begin
        total = total + hit_count[off];
        if (total > SUM_MAX) total = SUM_MAX;
      end
    end
    return total[47:0];
  endfunction

  function automatic void clear_ranking();
    for (int i = 0; i < TOP_K_DEF; i++) begin
      rank_hits[i] = '0;
      rank_ids[i]  = '0;
      rank_used[i] = 1'b0;
    end
  endfunction

  function automatic void update_profile(input item_t it);
    logic [31:0] off;
    logic [47:0] sum;
    int          pos;
    int          n;
    beat_t       b;
    case (it.op)
      OP_RECORD: begin
        off = it.pc - base_addr;
        if (it.pc >= base_addr && off < window_span()) begin
          if (!hit_count.exists(off)) hit_count[off] = 1;
          else if (hit_count[off] < COUNT_MAX) hit_count[off]++;
        end
      end
      OP_ADD: begin
        if (funcs_taken < MAX_FUNCTIONS_DEF) begin
          funcs_taken++;
          sum = range_hits(it.range_start, it.range_length);
          pos = 0;
          while (pos < TOP_K_DEF && rank_used[pos] && rank_hits[pos] >= sum) pos++;
          if (pos < TOP_K_DEF) begin
            for (int i = TOP_K_DEF - 1; i > pos; i--) begin
              rank_hits[i] = rank_hits[i - 1];
              rank_ids[i]  = rank_ids[i - 1];
              rank_used[i] = rank_used[i - 1];
            end
            rank_hits[pos] = sum;
            rank_ids[pos]  = it.func_id;
            rank_used[pos] = 1'b1;
          end
        end
      end
      OP_REPORT: begin
        n = 0;
        while (n < TOP_K_DEF && rank_used[n]) n++;
        if (n == 0) begin
          b = '{rank: '0, func_id: '0, hits: '0, entry_valid: 1'b0, last: 1'b1};
          expected_beats.push_back(b);
        end else begin
          for (int k = 0; k < n; k++) begin
            b.rank        = 4'(k);
            b.func_id     = rank_ids[k];
            b.hits        = rank_hits[k];
            b.entry_valid = 1'b1;
            b.last        = (k == n - 1);
            expected_beats.push_back(b);
          end
        end
        clear_ranking();
        funcs_taken = 0;
      end
      OP_CLEAR: begin
        hit_count.delete();
        clear_ranking();
        funcs_taken = 0;
      end
      default: begin
      end
    endcase
  endfunction

  function automatic item_t noise_item(input op_e op);
    item_t it;
    it.op           = op;
    it.pc           = $urandom;
    it.range_start  = $urandom;
    it.range_length = $urandom;
    it.func_id      = 16'($urandom);
    return it;
  endfunction

  task automatic send_item(input item_t it);
    int gap;
    gap = src_calm ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      item_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    item_if.valid        <= 1'b1;
    item_if.operation    <= it.op;
    item_if.pc           <= it.pc;
    item_if.range_start  <= it.range_start;
    item_if.range_length <= it.range_length;
    item_if.function_id  <= it.func_id;
    do begin
      @(posedge clk_i);
    end while (item_if.ready !== 1'b1);
    update_profile(it);
    items_sent++;
  endtask

  task automatic send_record(input logic [31:0] pc);
    item_t it;
    it    = noise_item(OP_RECORD);
    it.pc = pc;
    send_item(it);
  endtask

  task automatic send_add(input logic [31:0] start, input logic [31:0] len,
                          input logic [15:0] id);
    item_t it;
    it              = noise_item(OP_ADD);
    it.range_start  = start;
    it.range_length = len;
    it.func_id      = id;
    send_item(it);
  endtask

  task automatic idle_input();
    @(negedge clk_i);
    item_if.valid <= 1'b0;
  endtask

  // a report flushes everything queued before it, so the block is idle once its beats are in
  task automatic close_phase();
    send_item(noise_item(OP_REPORT));
    idle_input();
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_base(input logic [31:0] value);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    base_addr = value;
    cfg_writes++;
  endtask

  // full window at the reset base: window edges, pcs just outside, wrapping range, clear
  task automatic test_reset_window();
    logic [31:0] b;
    b         = BASE_RESET;
    src_calm  = 1'b0;
    sink_calm = 1'b0;
    send_item(noise_item(OP_REPORT));
    send_record(b);
    send_record(b + 32'd65535);
    send_record(b - 32'd1);
    send_record(b + 32'd65536);
    send_record(32'h0);
    send_record(32'hFFFF_FFFF);
    repeat (3) send_record(b + 32'd5);
    send_record(b + 32'd2);
    send_add(b, 32'd6, 16'hFFFF);
    send_add(32'h0, 32'h0, 16'h0000);
    send_add(b + 32'd65535, 32'hFFFF_FFFF, 16'h5A5A);
    send_item(noise_item(OP_REPORT));
    send_record(b + 32'd7);
    send_item(noise_item(OP_CLEAR));
    close_phase();
  endtask

  // one-word window at the top of memory, then base 0; counters stay put across base changes
  task automatic test_base_extremes();
    write_base(32'hFFFF_FFFF);
    repeat (2) send_record(32'hFFFF_FFFF);
    send_record(32'h0);
    send_record(32'hFFFF_FFFE);
    send_add(32'hFFFF_FFFF, 32'd1, 16'h0001);
    send_add(32'h0, 32'hFFFF_FFFF, 16'h0002);
    send_add(32'hFFFF_FFFE, 32'd1, 16'h0003);
    close_phase();
    write_base(32'h0);
    send_record(32'h0);
    send_record(32'h0000_FFFF);
    send_record(32'h0001_0000);
    send_record(32'h0000_8000);
    send_add(32'hFFFF_FFFF, 32'd2, 16'h0004);
    close_phase();
  endtask

  // overfill the list, then stall the result side so the block backs up into its input
  task automatic test_full_list_backpressure();
    logic [31:0] b;
    b = 32'hFFFF_FF00;
    write_base(b);
    repeat (80) send_record(b + 32'($urandom_range(0, 31)));
    send_add(b + 32'd3, 32'd2, 16'h1111);
    send_add(b + 32'd3, 32'd2, 16'h2222);
    for (int i = 0; i < 18; i++)
      send_add(b + 32'($urandom_range(0, 31)), 32'($urandom_range(1, 6)), 16'($urandom));
    send_add(b, 32'd0, 16'h3333);
    send_add(b, 32'd256, 16'h4444);
    src_calm  = 1'b1;
    sink_hold = 300;
    send_item(noise_item(OP_REPORT));
    repeat (6) send_record(b + 32'($urandom_range(0, 31)));
    send_add(b, 32'd32, 16'h7777);
    close_phase();
    src_calm = 1'b0;
  endtask

  task automatic test_random_phases();
    int              n_items;
    int              clear_phase;
    int              clear_at;
    int              r;
    longint unsigned span;
    logic [31:0]     b;
    item_t           it;
    clear_phase = $urandom_range(1, 6);
    clear_at    = $urandom_range(5, 30);
    for (int ph = 0; ph < 7; ph++) begin
      src_calm  = (ph == 0) || ($urandom_range(0, 5) == 0);
      sink_calm = (ph == 0) || ($urandom_range(0, 5) == 0);
      b = (ph == 1) ? 32'hFFFF_FF00 : 32'hFFFF_FFFF - 32'($urandom_range(0, 255));
      write_base(b);
      span    = window_span();
      n_items = $urandom_range(36, 56);
      for (int i = 0; i < n_items; i++) begin
        r = $urandom_range(0, 99);
        if (ph == clear_phase && i == clear_at) begin
          it = noise_item(OP_CLEAR);
        end else if (r < 50) begin
          // most hits land on a few hot words so sums differ and ties show up
          it    = noise_item(OP_RECORD);
          it.pc = b + 32'($urandom_range(0, (r < 40 && span > 16) ? 15 : int'(span - 1)));
        end else if (r < 75) begin
          it              = noise_item(OP_ADD);
          it.range_start  = b + 32'($urandom_range(0, int'(span - 1)));
          it.range_length = 32'($urandom_range(0, int'(span)));
        end else if (r < 80) begin
          it = noise_item(OP_ADD);
        end else if (r < 86) begin
          it = noise_item(OP_REPORT);
        end else if (r < 93) begin
          it    = noise_item(OP_RECORD);
          it.pc = b - 32'($urandom_range(1, 4));
        end else begin
          it = noise_item(OP_RECORD);
        end
        send_item(it);
      end
      close_phase();
    end
  endtask

  // result side: random stalls, plus a long hold-off on request
  initial begin
    int stall;
    stall        = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (sink_hold > 0) begin
        res_if.ready <= 1'b0;
        sink_hold--;
      end else if (stall > 0) begin
        res_if.ready <= 1'b0;
        stall--;
      end else begin
        res_if.ready <= 1'b1;
        if (!sink_calm) stall = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    beat_t exp_b;
    if (rst_ni === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected result beat: rank %0d id %h hits %0d valid %b last %b",
                 $time, res_if.rank, res_if.function_id_out, res_if.hit_total,
                 res_if.entry_valid, res_if.last);
        fail_count++;
      end else begin
        exp_b = expected_beats.pop_front();
        beats_checked++;
        if (res_if.rank !== exp_b.rank || res_if.function_id_out !== exp_b.func_id ||
            res_if.hit_total !== exp_b.hits || res_if.entry_valid !== exp_b.entry_valid ||
            res_if.last !== exp_b.last) begin
          $display("%0t: beat mismatch: expected rank %0d id %h hits %0d valid %b last %b",
                   $time, exp_b.rank, exp_b.func_id, exp_b.hits, exp_b.entry_valid,
                   exp_b.last);
          $display("%0t:                actual   rank %0d id %h hits %0d valid %b last %b",
                   $time, res_if.rank, res_if.function_id_out, res_if.hit_total,
                   res_if.entry_valid, res_if.last);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d beats still expected", $time, expected_beats.size());
      $display("pc_hit_profiler_top_k test failed");
      $finish;
    end
  end

  initial begin
    rst_ni               = 1'b0;
    cfg_we               = 1'b0;
    cfg_wdata            = '0;
    item_if.valid        = 1'b0;
    item_if.operation    = OP_RECORD;
    item_if.pc           = '0;
    item_if.range_start  = '0;
    item_if.range_length = '0;
    item_if.function_id  = '0;
    base_addr            = BASE_RESET;
    funcs_taken          = 0;
    src_calm             = 1'b0;
    sink_calm            = 1'b0;
    sink_hold            = 0;
    cycle_count          = 0;
    fail_count           = 0;
    items_sent           = 0;
    beats_checked        = 0;
    cfg_writes           = 0;
    clear_ranking();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_window();
    test_base_extremes();
    test_full_list_backpressure();
    test_random_phases();

    idle_input();
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("run covered %0d items and %0d checked result beats over %0d base settings",
             items_sent, beats_checked, cfg_writes);
    $display("window sizes 1 to %0d words, full top list, stalled results, clear, %0d errors",
             CODE_WORDS_DEF, fail_count);
    if (fail_count == 0) begin
      $display("pc_hit_profiler_top_k test passed");
    end else begin
      $display("pc_hit_profiler_top_k test failed");
    end
    $finish;
  end

endmodule
